// ===== rtl/mfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfr_pkg
// Shared types, codes and constants for the meter frame receiver.
// ----------------------------------------------------------------------------
package mfr_pkg;

  // Frame constants
  localparam logic [7:0] StartByte     = 8'h68;
  localparam logic [7:0] EndByte       = 8'h16;
  localparam logic [7:0] FrameOverhead = 8'd9;
  localparam logic [7:0] LenCap        = 8'd246;

  // Register reset values
  localparam logic [7:0]  MaxHuntBytesRst     = 8'd30;
  localparam logic [15:0] HuntTimeoutTicksRst = 16'd2;
  localparam logic [15:0] ByteTimeoutTicksRst = 16'd100;
  localparam logic [7:0]  MaxDataLenRst       = 8'd128;

  // Register indexes
  localparam logic [1:0] CFG_MAX_HUNT     = 2'd0;
  localparam logic [1:0] CFG_HUNT_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_BYTE_TIMEOUT = 2'd2;
  localparam logic [1:0] CFG_MAX_DATA_LEN = 2'd3;

  // Item modes
  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_ARM  = 2'd2;

  // Receive phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HUNT = 3'd1;
  localparam logic [2:0] PH_ADDR = 3'd2;
  localparam logic [2:0] PH_CTRL = 3'd3;
  localparam logic [2:0] PH_LEN  = 3'd4;
  localparam logic [2:0] PH_DATA = 3'd5;
  localparam logic [2:0] PH_CS   = 3'd6;
  localparam logic [2:0] PH_END  = 3'd7;

  localparam logic [7:0] AddrBytes = 8'd4;

  typedef enum logic [3:0] {
    ST_OK             = 4'd0,
    ST_HEADER_MISSING = 4'd1,
    ST_ADDR_TO        = 4'd2,
    ST_CTRL_TO        = 4'd3,
    ST_LEN_TO         = 4'd4,
    ST_TOO_LONG       = 4'd5,
    ST_DATA_TO        = 4'd6,
    ST_CS_TO          = 4'd7,
    ST_BAD_CS         = 4'd8,
    ST_END_TO         = 4'd9,
    ST_BAD_END        = 4'd10
  } status_e;

  typedef struct packed {
    logic [7:0]  max_hunt_bytes;
    logic [15:0] hunt_timeout_ticks;
    logic [15:0] byte_timeout_ticks;
    logic [7:0]  max_data_len;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [7:0] byte_position;
    logic       done_res;
    status_e    status;
    logic [7:0] frame_length;
  } result_t;

  // Status reported when the wait in a phase runs out
  function automatic status_e timeout_status(logic [2:0] phase);
    status_e st;
    case (phase)
      PH_HUNT: st = ST_HEADER_MISSING;
      PH_ADDR: st = ST_ADDR_TO;
      PH_CTRL: st = ST_CTRL_TO;
      PH_LEN:  st = ST_LEN_TO;
      PH_DATA: st = ST_DATA_TO;
      PH_CS:   st = ST_CS_TO;
      PH_END:  st = ST_END_TO;
      default: st = ST_OK;
    endcase
    return st;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mfr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfr_if
// Valid/ready channels for receiver input items and result items.
// ----------------------------------------------------------------------------
interface mfr_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface mfr_result_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] byte_value;
  logic [7:0] byte_position;
  logic       done_res;
  logic [3:0] status;
  logic [7:0] frame_length;

  modport source (output valid, output byte_valid, output byte_value,
                  output byte_position, output done_res, output status,
                  output frame_length, input ready);
  modport sink   (input valid, input byte_valid, input byte_value,
                  input byte_position, input done_res, input status,
                  input frame_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/mfr_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfr_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module mfr_cfg_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [15:0]  cfg_data_i,
  output mfr_pkg::cfg_t     cfg_o
);

  mfr_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_hunt_bytes     <= mfr_pkg::MaxHuntBytesRst;
      cfg_q.hunt_timeout_ticks <= mfr_pkg::HuntTimeoutTicksRst;
      cfg_q.byte_timeout_ticks <= mfr_pkg::ByteTimeoutTicksRst;
      cfg_q.max_data_len       <= mfr_pkg::MaxDataLenRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mfr_pkg::CFG_MAX_HUNT:     cfg_q.max_hunt_bytes     <= cfg_data_i[7:0];
        mfr_pkg::CFG_HUNT_TIMEOUT: cfg_q.hunt_timeout_ticks <= cfg_data_i;
        mfr_pkg::CFG_BYTE_TIMEOUT: cfg_q.byte_timeout_ticks <= cfg_data_i;
        mfr_pkg::CFG_MAX_DATA_LEN: cfg_q.max_data_len       <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/mfr_frame_fsm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfr_frame_fsm
// Frame parser: hunt, header, data, checksum and end byte, with tick timeouts.
// ----------------------------------------------------------------------------
module mfr_frame_fsm (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mfr_pkg::cfg_t  cfg_i,
  input  wire logic          in_fire_i,
  input  wire mfr_pkg::item_t item_i,
  output logic               res_valid_o,
  output mfr_pkg::result_t   res_o
);

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  field_q, field_d;
  logic [7:0]  hunt_q, hunt_d;
  logic [15:0] idle_q, idle_d;
  logic [7:0]  dlen_q, dlen_d;
  logic [7:0]  pos_q, pos_d;

  logic [7:0]  rx;
  logic [7:0]  field_inc;
  logic [7:0]  hunt_inc;
  logic [15:0] idle_inc;
  logic [15:0] tick_limit;
  logic [7:0]  len_limit;

  assign rx         = item_i.rx_byte;
  assign field_inc  = field_q + 8'd1;
  assign hunt_inc   = hunt_q + 8'd1;
  assign idle_inc   = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
  assign tick_limit = (phase_q == mfr_pkg::PH_HUNT) ? cfg_i.hunt_timeout_ticks
                                                    : cfg_i.byte_timeout_ticks;
  assign len_limit  = (cfg_i.max_data_len > mfr_pkg::LenCap) ? mfr_pkg::LenCap
                                                             : cfg_i.max_data_len;

  always_comb begin
    phase_d     = phase_q;
    sum_d       = sum_q;
    field_d     = field_q;
    hunt_d      = hunt_q;
    idle_d      = idle_q;
    dlen_d      = dlen_q;
    pos_d       = pos_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (in_fire_i) begin
      case (item_i.mode)
        mfr_pkg::MODE_ARM: begin
          phase_d = mfr_pkg::PH_HUNT;
          sum_d   = '0;
          field_d = '0;
          hunt_d  = '0;
          idle_d  = '0;
          dlen_d  = '0;
          pos_d   = '0;
        end
        mfr_pkg::MODE_TICK: begin
          if (phase_q != mfr_pkg::PH_IDLE) begin
            idle_d = idle_inc;
            if (idle_inc >= tick_limit) begin
              res_valid_o    = 1'b1;
              res_o.done_res = 1'b1;
              res_o.status   = mfr_pkg::timeout_status(phase_q);
              phase_d        = mfr_pkg::PH_IDLE;
            end
          end
        end
        mfr_pkg::MODE_BYTE: begin
          if (phase_q != mfr_pkg::PH_IDLE) begin
            idle_d = '0;
            // default: the byte is taken into the frame; rejects override below
            res_valid_o         = 1'b1;
            res_o.byte_valid    = 1'b1;
            res_o.byte_value    = rx;
            res_o.byte_position = pos_q;
            pos_d               = pos_q + 8'd1;
            sum_d               = sum_q + rx;
            case (phase_q)
              mfr_pkg::PH_HUNT: begin
                hunt_d = hunt_inc;
                if (rx == mfr_pkg::StartByte) begin
                  res_o.byte_position = '0;
                  pos_d               = 8'd1;
                  sum_d               = rx;
                  field_d             = '0;
                  phase_d             = mfr_pkg::PH_ADDR;
                end else begin
                  res_o = '0;
                  pos_d = pos_q;
                  sum_d = sum_q;
                  if (hunt_inc >= cfg_i.max_hunt_bytes) begin
                    res_o.done_res = 1'b1;
                    res_o.status   = mfr_pkg::ST_HEADER_MISSING;
                    phase_d        = mfr_pkg::PH_IDLE;
                  end else begin
                    res_valid_o = 1'b0;
                  end
                end
              end
              mfr_pkg::PH_ADDR: begin
                field_d = field_inc;
                if (field_inc >= mfr_pkg::AddrBytes) phase_d = mfr_pkg::PH_CTRL;
              end
              mfr_pkg::PH_CTRL: begin
                phase_d = mfr_pkg::PH_LEN;
              end
              mfr_pkg::PH_LEN: begin
                if (rx > len_limit) begin
                  res_o          = '0;
                  res_o.done_res = 1'b1;
                  res_o.status   = mfr_pkg::ST_TOO_LONG;
                  pos_d          = pos_q;
                  sum_d          = sum_q;
                  phase_d        = mfr_pkg::PH_IDLE;
                end else begin
                  dlen_d  = rx;
                  field_d = '0;
                  phase_d = (rx == 8'd0) ? mfr_pkg::PH_CS : mfr_pkg::PH_DATA;
                end
              end
              mfr_pkg::PH_DATA: begin
                field_d = field_inc;
                if (field_inc >= dlen_q) phase_d = mfr_pkg::PH_CS;
              end
              mfr_pkg::PH_CS: begin
                if (rx != sum_q) begin
                  res_o          = '0;
                  res_o.done_res = 1'b1;
                  res_o.status   = mfr_pkg::ST_BAD_CS;
                  pos_d          = pos_q;
                  sum_d          = sum_q;
                  phase_d        = mfr_pkg::PH_IDLE;
                end else begin
                  phase_d = mfr_pkg::PH_END;
                end
              end
              mfr_pkg::PH_END: begin
                if (rx != mfr_pkg::EndByte) begin
                  res_o          = '0;
                  res_o.done_res = 1'b1;
                  res_o.status   = mfr_pkg::ST_BAD_END;
                  pos_d          = pos_q;
                  sum_d          = sum_q;
                end else begin
                  res_o.done_res     = 1'b1;
                  res_o.status       = mfr_pkg::ST_OK;
                  res_o.frame_length = dlen_q + mfr_pkg::FrameOverhead;
                end
                phase_d = mfr_pkg::PH_IDLE;
              end
              default: begin
                res_valid_o = 1'b0;
                res_o       = '0;
                pos_d       = pos_q;
                sum_d       = sum_q;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mfr_pkg::PH_IDLE;
      sum_q   <= '0;
      field_q <= '0;
      hunt_q  <= '0;
      idle_q  <= '0;
      dlen_q  <= '0;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      field_q <= field_d;
      hunt_q  <= hunt_d;
      idle_q  <= idle_d;
      dlen_q  <= dlen_d;
      pos_q   <= pos_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mfr_out_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfr_out_fifo
// Two-entry result buffer; input side keeps running while one result waits.
// ----------------------------------------------------------------------------
module mfr_out_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire mfr_pkg::result_t push_data_i,
  output logic                  ready_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output mfr_pkg::result_t      data_o
);

  mfr_pkg::result_t slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/meter_frame_receiver.sv =====
// A result is written into the result buffer when its item is accepted and is offered on result_o from there.
// Throughput: one item per cycle while the result buffer is not full; the parser updates all state in one pass.
// A two-entry result buffer keeps item_i ready while one result waits unread.
// Reset (async, active low) leaves the receiver unarmed, buffer empty and the
// configuration registers at their default values.
`default_nettype none
// ----------------------------------------------------------------------------
// meter_frame_receiver
// Top level: config registers, frame parser and result buffer.
// ----------------------------------------------------------------------------
module meter_frame_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  mfr_item_if.sink         item_i,
  mfr_result_if.source     result_o
);

  mfr_pkg::cfg_t    cfg;
  mfr_pkg::item_t   item;
  mfr_pkg::result_t res;
  mfr_pkg::result_t head;
  logic             res_valid;
  logic             in_fire;
  logic             buf_ready;

  assign item.mode    = item_i.mode;
  assign item.rx_byte = item_i.rx_byte;
  assign item_i.ready = buf_ready;
  assign in_fire      = item_i.valid && buf_ready;

  mfr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mfr_frame_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_fire_i   (in_fire),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mfr_out_fifo u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (buf_ready),
    .pop_i       (result_o.valid && result_o.ready),
    .valid_o     (result_o.valid),
    .data_o      (head)
  );

  assign result_o.byte_valid    = head.byte_valid;
  assign result_o.byte_value    = head.byte_value;
  assign result_o.byte_position = head.byte_position;
  assign result_o.done_res      = head.done_res;
  assign result_o.status        = head.status;
  assign result_o.frame_length  = head.frame_length;

`ifndef ASSERT_OFF
  // every result is a frame byte, a finish, or both
  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.byte_valid || result_o.done_res))
    else $error("result carries neither byte nor finish");

  // a good frame ends on its end byte with a sane length
  a_ok_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.done_res && (result_o.status == mfr_pkg::ST_OK))
      |-> (result_o.byte_valid && (result_o.byte_value == mfr_pkg::EndByte)
           && (result_o.frame_length >= mfr_pkg::FrameOverhead)))
    else $error("ok status without end byte or length");

  // position zero is always the start byte
  a_start_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.byte_valid && (result_o.byte_position == 8'd0))
      |-> (result_o.byte_value == mfr_pkg::StartByte))
    else $error("frame byte at position zero is not the start byte");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_meter_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// tb_meter_frame_receiver
// Drives meter reply frames, stray bytes and ticks into the receiver and checks
// every reported byte and completion status against a cycle-free parser model.
// ----------------------------------------------------------------------------
module tb_meter_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import mfr_pkg::*;

  localparam logic [1:0] ModeSpare  = 2'd3;
  localparam int         CycleLimit = 200000;

  typedef enum {
    FLAW_NONE, FLAW_TOO_LONG, FLAW_BAD_CS, FLAW_BAD_END, FLAW_CUT, FLAW_STALL,
    FLAW_NO_START
  } flaw_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  mfr_item_if   item_bus ();
  mfr_result_if result_bus ();

  meter_frame_receiver u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_bus),
    .result_o   (result_bus)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Register copy and parser state mirrored by the checker
  cfg_t       cfg_now;
  logic [2:0] rx_phase;
  logic [7:0] sum_acc;
  logic [7:0] field_cnt;
  logic [7:0] hunt_cnt;
  logic [15:0] tick_cnt;
  logic [7:0] data_len;
  logic [7:0] pos_next;

  status_e timeout_code [8] = '{ST_OK, ST_HEADER_MISSING, ST_ADDR_TO, ST_CTRL_TO,
                                ST_LEN_TO, ST_DATA_TO, ST_CS_TO, ST_END_TO};

  item_t   items_to_send [$];
  result_t reports_due [$];

  bit quiet;
  bit item_taken;
  int rx_hold_left;
  int errors;
  int items_queued;
  int items_accepted;
  int results_seen;
  int frame_bytes;
  int good_frames;
  int settings_used;
  int status_hits [16];

  function automatic int len_limit();
    return (cfg_now.max_data_len > LenCap) ? int'(LenCap) : int'(cfg_now.max_data_len);
  endfunction

  function automatic result_t take_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    r.byte_valid    = 1'b1;
    r.byte_value    = b;
    r.byte_position = pos_next;
    pos_next = pos_next + 8'd1;
    sum_acc  = sum_acc + b;
    return r;
  endfunction

  function automatic result_t end_attempt(input status_e st);
    result_t r;
    r = '0;
    r.done_res = 1'b1;
    r.status   = st;
    rx_phase   = PH_IDLE;
    return r;
  endfunction

  // One input item through the parser; returns 1 when it yields a report
  function automatic bit rx_parse_step(input item_t it, output result_t r);
    logic [15:0] tick_lim;
    r = '0;
    if (it.mode == MODE_ARM) begin
      rx_phase  = PH_HUNT;
      sum_acc   = '0;
      field_cnt = '0;
      hunt_cnt  = '0;
      tick_cnt  = '0;
      data_len  = '0;
      pos_next  = '0;
      return 1'b0;
    end
    if (it.mode == ModeSpare || rx_phase == PH_IDLE) return 1'b0;
    if (it.mode == MODE_TICK) begin
      tick_lim = (rx_phase == PH_HUNT) ? cfg_now.hunt_timeout_ticks
                                       : cfg_now.byte_timeout_ticks;
      if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt < tick_lim) return 1'b0;
      r = end_attempt(timeout_code[rx_phase]);
      return 1'b1;
    end
    tick_cnt = '0;
    case (rx_phase)
      PH_HUNT: begin
        hunt_cnt = hunt_cnt + 8'd1;
        if (it.rx_byte == StartByte) begin
          sum_acc   = '0;
          pos_next  = '0;
          field_cnt = '0;
          rx_phase  = PH_ADDR;
          r = take_byte(it.rx_byte);
        end else if (hunt_cnt >= cfg_now.max_hunt_bytes) begin
          r = end_attempt(ST_HEADER_MISSING);
        end else begin
          return 1'b0;
        end
      end
      PH_ADDR: begin
        field_cnt = field_cnt + 8'd1;
        if (field_cnt >= AddrBytes) rx_phase = PH_CTRL;
        r = take_byte(it.rx_byte);
      end
      PH_CTRL: begin
        rx_phase = PH_LEN;
        r = take_byte(it.rx_byte);
      end
      PH_LEN: begin
        if (int'(it.rx_byte) > len_limit()) begin
          r = end_attempt(ST_TOO_LONG);
        end else begin
          data_len  = it.rx_byte;
          field_cnt = '0;
          rx_phase  = (it.rx_byte == 8'd0) ? PH_CS : PH_DATA;
          r = take_byte(it.rx_byte);
        end
      end
      PH_DATA: begin
        field_cnt = field_cnt + 8'd1;
        if (field_cnt >= data_len) rx_phase = PH_CS;
        r = take_byte(it.rx_byte);
      end
      PH_CS: begin
        if (it.rx_byte != sum_acc) begin
          r = end_attempt(ST_BAD_CS);
        end else begin
          rx_phase = PH_END;
          r = take_byte(it.rx_byte);
        end
      end
      default: begin
        if (it.rx_byte != EndByte) begin
          r = end_attempt(ST_BAD_END);
        end else begin
          r = take_byte(it.rx_byte);
          r.done_res     = 1'b1;
          r.status       = ST_OK;
          r.frame_length = data_len + FrameOverhead;
          rx_phase       = PH_IDLE;
        end
      end
    endcase
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch in %s: got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic push_item(input logic [1:0] m, input logic [7:0] b);
    item_t it;
    it.mode    = m;
    it.rx_byte = b;
    items_to_send.push_back(it);
    items_queued++;
  endtask

  // Ticks before a byte, kept below the limit so the wait survives
  task automatic push_gap(input int limit);
    int n;
    n = 0;
    if (limit > 1 && $urandom_range(3) == 0)
      n = $urandom_range(1, (limit - 1 > 3) ? 3 : limit - 1);
    repeat (n) push_item(MODE_TICK, 8'($urandom));
  endtask

  // Arm, hunt noise, then a frame that is clean or broken as asked
  task automatic push_frame(input int len, input flaw_e flaw);
    logic [7:0] fb [$];
    logic [7:0] sum;
    logic [7:0] nb;
    int eff_hunt, n_noise, cut_at, stall_at, lim_t, k;
    eff_hunt = (cfg_now.max_hunt_bytes == 8'd0) ? 1 : int'(cfg_now.max_hunt_bytes);
    push_item(MODE_ARM, 8'($urandom));
    if (flaw == FLAW_NO_START) n_noise = eff_hunt;
    else n_noise = $urandom_range(0, (eff_hunt > 4) ? 3 : eff_hunt - 1);
    for (k = 0; k < n_noise; k++) begin
      push_gap(int'(cfg_now.hunt_timeout_ticks));
      nb = 8'($urandom);
      if (nb == StartByte) nb = nb + 8'd1;
      push_item(MODE_BYTE, nb);
    end
    if (flaw == FLAW_NO_START) return;

    fb.push_back(StartByte);
    repeat (5) fb.push_back(8'($urandom));  // address and control
    fb.push_back(8'(len));
    if (len <= len_limit()) begin
      repeat (len) fb.push_back(8'($urandom));
      sum = '0;
      foreach (fb[j]) sum = sum + fb[j];
      fb.push_back((flaw == FLAW_BAD_CS) ? sum + 8'($urandom_range(1, 255)) : sum);
      fb.push_back((flaw == FLAW_BAD_END) ? EndByte ^ 8'($urandom_range(1, 255)) : EndByte);
    end

    cut_at   = fb.size();
    stall_at = -1;
    if (flaw == FLAW_CUT) cut_at = $urandom_range(1, fb.size() - 1);
    if (flaw == FLAW_STALL) begin
      stall_at = $urandom_range(0, fb.size() - 1);
      cut_at   = stall_at;
    end
    for (k = 0; k < cut_at; k++) begin
      push_gap(int'((k == 0) ? cfg_now.hunt_timeout_ticks : cfg_now.byte_timeout_ticks));
      push_item(MODE_BYTE, fb[k]);
    end
    if (stall_at >= 0) begin
      lim_t = int'((stall_at == 0) ? cfg_now.hunt_timeout_ticks : cfg_now.byte_timeout_ticks);
      // long limits just leave the frame cut short
      if (lim_t <= 24) repeat ((lim_t == 0) ? 1 : lim_t) push_item(MODE_TICK, 8'($urandom));
    end
  endtask

  task automatic push_random(input int budget);
    int first, pick, lim, len;
    flaw_e flaw;
    first = items_queued;
    while (items_queued - first < budget) begin
      lim  = len_limit();
      pick = $urandom_range(99);
      if (pick < 50)      flaw = FLAW_NONE;
      else if (pick < 58) flaw = FLAW_TOO_LONG;
      else if (pick < 66) flaw = FLAW_BAD_CS;
      else if (pick < 74) flaw = FLAW_BAD_END;
      else if (pick < 82) flaw = FLAW_CUT;
      else if (pick < 92) flaw = FLAW_STALL;
      else                flaw = FLAW_NO_START;
      if (flaw == FLAW_TOO_LONG)        len = $urandom_range(lim + 1, 255);
      else if ($urandom_range(19) == 0) len = $urandom_range(0, (lim > 40) ? 40 : lim);
      else                              len = $urandom_range(0, (lim > 6) ? 6 : lim);
      // stray items between attempts
      if ($urandom_range(15) == 0) begin
        push_item($urandom_range(1) ? ModeSpare : MODE_TICK, 8'($urandom));
        push_item(MODE_BYTE, 8'($urandom));
      end
      push_frame(len, flaw);
    end
  endtask

  task automatic set_config(input logic [7:0] hunt_bytes, input logic [15:0] hunt_ticks,
                            input logic [15:0] byte_ticks, input logic [7:0] data_max);
    logic [15:0] vals [4];
    logic [1:0]  idxs [4];
    int k;
    vals = '{16'(hunt_bytes), hunt_ticks, byte_ticks, 16'(data_max)};
    idxs = '{CFG_MAX_HUNT, CFG_HUNT_TIMEOUT, CFG_BYTE_TIMEOUT, CFG_MAX_DATA_LEN};
    for (k = 0; k < 4; k++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idxs[k];
      cfg_data_i <= vals[k];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_now = {hunt_bytes, hunt_ticks, byte_ticks, data_max};
    settings_used++;
  endtask

  // Wait for all items to go in and all reports to come out, then let the
  // pipeline settle past any item that produced nothing
  task automatic drain();
    while (items_to_send.size() != 0 || reports_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Source side: hold an offered item until it is taken
  always @(negedge clk_i) begin : source_drive
    if (!rst_ni) begin
      item_bus.valid <= 1'b0;
    end else if ((item_bus.valid && !item_taken) ||
                 (items_to_send.size() != 0 && (quiet || $urandom_range(99) >= 12))) begin
      item_bus.valid   <= 1'b1;
      item_bus.mode    <= items_to_send[0].mode;
      item_bus.rx_byte <= items_to_send[0].rx_byte;
    end else begin
      item_bus.valid <= 1'b0;
    end
  end

  always @(negedge clk_i) begin : sink_ready
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= quiet || ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk_i) begin : track_items
    item_t   seen;
    result_t r;
    item_taken = 1'b0;
    if (rst_ni && item_bus.valid && item_bus.ready) begin
      item_taken   = 1'b1;
      seen.mode    = item_bus.mode;
      seen.rx_byte = item_bus.rx_byte;
      if (rx_parse_step(seen, r)) reports_due.push_back(r);
      void'(items_to_send.pop_front());
      items_accepted++;
    end
  end

  always @(posedge clk_i) begin : check_reports
    result_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      results_seen++;
      if (result_bus.byte_valid === 1'b1) frame_bytes++;
      if (result_bus.done_res === 1'b1) begin
        status_hits[result_bus.status]++;
        if (result_bus.status == ST_OK) good_frames++;
      end
      if (reports_due.size() == 0) begin
        report_mismatch("transaction with nothing due", 1, 0);
      end else begin
        want = reports_due.pop_front();
        if (result_bus.byte_valid !== want.byte_valid)
          report_mismatch("byte_valid", result_bus.byte_valid, want.byte_valid);
        if (result_bus.byte_value !== want.byte_value)
          report_mismatch("byte_value", result_bus.byte_value, want.byte_value);
        if (result_bus.byte_position !== want.byte_position)
          report_mismatch("byte_position", result_bus.byte_position, want.byte_position);
        if (result_bus.done_res !== want.done_res)
          report_mismatch("done_res", result_bus.done_res, want.done_res);
        if (result_bus.status !== want.status)
          report_mismatch("status", result_bus.status, int'(want.status));
        if (result_bus.frame_length !== want.frame_length)
          report_mismatch("frame_length", result_bus.frame_length, want.frame_length);
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clk_i);
    $display("run stopped after %0d cycles with %0d reports outstanding",
             cycle_count, reports_due.size());
    $display("FAIL meter_frame_receiver");
    $finish;
  end

  initial begin : stimulus
    int k, codes_seen;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_MAX_HUNT;
    cfg_data_i       = '0;
    item_bus.valid   = 1'b0;
    item_bus.mode    = MODE_BYTE;
    item_bus.rx_byte = '0;
    result_bus.ready = 1'b0;
    quiet            = 1'b0;
    rx_hold_left     = 0;
    cfg_now  = {MaxHuntBytesRst, HuntTimeoutTicksRst, ByteTimeoutTicksRst, MaxDataLenRst};
    rx_phase = PH_IDLE;
    sum_acc  = '0;
    field_cnt = '0;
    hunt_cnt = '0;
    tick_cnt = '0;
    data_len = '0;
    pos_next = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: unarmed items are dropped, then a minimal frame, an oversize
    // length and a bad checksum at the default settings
    push_item(MODE_BYTE, StartByte);
    push_item(MODE_TICK, 8'hFF);
    push_item(ModeSpare, 8'h00);
    push_frame(0, FLAW_NONE);
    push_frame(int'(MaxDataLenRst) + 1, FLAW_TOO_LONG);
    push_frame(1, FLAW_BAD_CS);
    push_random(160);
    drain();

    // Tightest limits, no idling on either side
    quiet = 1'b1;
    set_config(8'd1, 16'd1, 16'd1, 8'd0);
    push_random(200);
    drain();
    quiet = 1'b0;

    // Widest limits; the sink stalls long enough to back up the input
    set_config(8'd255, 16'hFFFF, 16'hFFFF, 8'd255);
    @(posedge clk_i);
    rx_hold_left = 300;
    push_frame(int'(LenCap), FLAW_NONE);
    push_frame(int'(LenCap) + 1, FLAW_TOO_LONG);
    push_random(250);
    drain();

    // Zero limits: first non-start byte or first tick ends the attempt
    set_config(8'd0, 16'd0, 16'd0, LenCap);
    push_frame(0, FLAW_NO_START);
    push_frame(0, FLAW_STALL);
    push_random(200);
    drain();

    for (k = 0; k < 4; k++) begin
      set_config(8'($urandom_range(1, 12)), 16'($urandom_range(1, 6)),
                 16'($urandom_range(1, 8)), 8'($urandom_range(0, 20)));
      push_random(200);
      drain();
    end

    codes_seen = 0;
    for (k = 0; k < 16; k++) if (status_hits[k] != 0) codes_seen++;
    $display("%0d items over %0d register settings gave %0d reports: %0d frame bytes",
             items_accepted, settings_used + 1, results_seen, frame_bytes);
    $display("%0d good frames, %0d distinct completion statuses, %0d mismatches",
             good_frames, codes_seen, errors);
    if (errors == 0) begin
      $display("PASS meter_frame_receiver");
    end else begin
      $display("FAIL meter_frame_receiver");
    end
    $finish;
  end

endmodule
